/* hw/rtl/pal_pkg.sv */
`timescale 1ns / 1ps

package pal_pkg;

    localparam int PAL_CAPACITY = 32;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_DUMP   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef struct packed {
        t_action            action;
        logic [5:0]         position;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] element;
        logic [5:0]         length;
        logic               final_result;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_COMMIT,
        S_RESP,
        S_DUMP_RD,
        S_DUMP_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic init;
        logic read;
        logic shift;
        logic commit;
        logic load_resp;
        logic load_elem;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_action action;
        logic    code_ok;
        logic    no_shift;
        logic    shift_done;
        logic    dump_last;
        logic    out_free;
    } t_sts;

endpackage

/* hw/rtl/pal_ctrl.sv */
`timescale 1ns / 1ps

module pal_ctrl import pal_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (!i_sts.code_ok) begin
                    n_state = S_RESP;
                end else if (i_sts.action == ACT_DUMP) begin
                    n_state = S_DUMP_RD;
                end else if (i_sts.no_shift) begin
                    n_state = S_COMMIT;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: begin
                n_state = i_sts.shift_done ? S_COMMIT : S_SHIFT_RD;
            end
            S_COMMIT: n_state = S_RESP;
            S_RESP: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_DUMP_RD: n_state = S_DUMP_OUT;
            S_DUMP_OUT: begin
                if (i_sts.out_free) n_state = i_sts.dump_last ? S_IDLE : S_DUMP_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            S_DECODE:   o_cmd.init      = 1'b1;
            S_SHIFT_RD: o_cmd.read      = 1'b1;
            S_SHIFT_WR: o_cmd.shift     = 1'b1;
            S_COMMIT:   o_cmd.commit    = 1'b1;
            S_RESP:     o_cmd.load_resp = i_sts.out_free;
            S_DUMP_RD:  o_cmd.read      = 1'b1;
            S_DUMP_OUT: o_cmd.load_elem = i_sts.out_free;
            default:    o_cmd           = '0;
        endcase
    end

endmodule

/* hw/rtl/pal_datapath.sv */
`timescale 1ns / 1ps

module pal_datapath import pal_pkg::*; #(
    parameter int CAPACITY = PAL_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_cmd      i_cmd,
    input  logic      i_out_ready,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > 6) ? CW : 6) + 1;

    logic signed [31:0] r_mem [CAPACITY];

    t_action            r_act;
    logic [5:0]         r_pos;
    logic signed [31:0] r_val;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_idx;
    logic signed [31:0] r_rdata;
    t_status            r_code;
    logic               r_out_valid;
    t_out_item          r_out;

    t_status            code;
    logic [XW-1:0]      pos_x;
    logic [XW-1:0]      cnt_x;
    logic [XW-1:0]      idx_x;
    logic               full;
    logic               empty;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic signed [31:0] wr_data;
    logic               out_free;

    assign pos_x = XW'(r_pos);
    assign cnt_x = XW'(r_count);
    assign idx_x = XW'(r_idx);
    assign full  = (cnt_x == XW'(CAPACITY));
    assign empty = (r_count == '0);

    always_comb begin
        unique case (r_act)
            ACT_APPEND: code = full ? ST_FULL : ST_OK;
            ACT_INSERT: begin
                if (full) code = ST_FULL;
                else if (r_pos == '0 || pos_x > cnt_x + XW'(1)) code = ST_BADPOS;
                else code = ST_OK;
            end
            ACT_DELETE: begin
                if (empty) code = ST_EMPTY;
                else if (r_pos == '0 || pos_x > cnt_x) code = ST_BADPOS;
                else code = ST_OK;
            end
            ACT_DUMP: code = empty ? ST_EMPTY : ST_OK;
            default:  code = ST_OK;
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts            = '0;
        o_sts.action     = r_act;
        o_sts.code_ok    = (code == ST_OK);
        o_sts.no_shift   = (r_act == ACT_APPEND)
                        || (r_act == ACT_INSERT && pos_x == cnt_x + XW'(1))
                        || (r_act == ACT_DELETE && pos_x == cnt_x);
        // insert walks down to index position (one above the target slot), delete walks up to count-2
        o_sts.shift_done = (r_act == ACT_INSERT) ? (idx_x == pos_x)
                                                 : (idx_x + XW'(2) == cnt_x);
        o_sts.dump_last  = (idx_x + XW'(1) == cnt_x);
        o_sts.out_free   = out_free;
    end

    always_comb begin
        unique case (r_act)
            ACT_INSERT: rd_addr = r_idx - AW'(1);
            ACT_DELETE: rd_addr = r_idx + AW'(1);
            default:    rd_addr = r_idx;
        endcase
    end

    always_comb begin
        wr_en   = i_cmd.shift || (i_cmd.commit && r_act != ACT_DELETE);
        wr_data = i_cmd.shift ? r_rdata : r_val;
        if (i_cmd.shift) wr_addr = r_idx;
        else if (r_act == ACT_INSERT) wr_addr = AW'(r_pos - 6'd1);
        else wr_addr = AW'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) r_rdata <= r_mem[rd_addr];
        if (wr_en) r_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_act <= i_in_item.action;
            r_pos <= i_in_item.position;
            r_val <= i_in_item.value;
        end
        if (i_cmd.init) begin
            r_code <= code;
            unique case (r_act)
                ACT_INSERT: r_idx <= AW'(r_count);
                ACT_DELETE: r_idx <= AW'(r_pos - 6'd1);
                default:    r_idx <= '0;
            endcase
        end else if (i_cmd.shift) begin
            r_idx <= (r_act == ACT_INSERT) ? r_idx - AW'(1) : r_idx + AW'(1);
        end else if (i_cmd.load_elem) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= (r_act == ACT_DELETE) ? r_count - CW'(1) : r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_resp || i_cmd.load_elem) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_resp) begin
            r_out.status       <= r_code;
            r_out.element      <= '0;
            r_out.length       <= 6'(r_count);
            r_out.final_result <= 1'b1;
        end else if (i_cmd.load_elem) begin
            r_out.status       <= ST_OK;
            r_out.element      <= r_rdata;
            r_out.length       <= 6'(r_count);
            r_out.final_result <= o_sts.dump_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* hw/rtl/positional_array_list.sv */
`timescale 1ns / 1ps
// ordered list of up to CAPACITY signed words with append, insert, delete and dump
// input channel: i_in_valid / o_in_ready carry one item (action, position, value)
// output channel: o_out_valid / i_out_ready carry result items (status, element,
//   length, final_result); final_result marks the last result of an input item
// one item is worked on at a time, through a single-port list memory
// append, or insert at the end, or delete of the last entry: decode, commit, then the
//   result loads in the response state and is shown the cycle after the load
// rejected item (full, empty, bad position): decode, then the response load
// insert/delete with a shift: decode, then a memory read and a memory write per moved
//   entry (up to CAPACITY-1 entries), then commit and response
// dump: decode, then per entry a memory read, then an output load;
//   n entries give n items, an empty list gives one empty status
// the next item is accepted the cycle after the last result is loaded into the
//   output register, even while that result still waits to be taken
// a stalled receiver holds the output register; the block waits before loading more
// reset clears the length to an empty list and drops any pending result;
//   list contents are not cleared
module positional_array_list import pal_pkg::*; #(
    parameter int CAPACITY = PAL_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_cmd cmd;
    t_sts sts;

    pal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    pal_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_resp || cmd.load_elem) |-> (!o_out_valid || i_out_ready))
        else $error("output register overwritten");

    // one item at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while busy");

    // only dump entries can be non-final, and they are always ok
    a_nonfinal_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.final_result) |-> (o_out_item.status == ST_OK))
        else $error("non-final result with error status");

    // a status-only result never carries an element
    a_resp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_resp |=> (o_out_item.element == '0 && o_out_item.final_result))
        else $error("status result malformed");

endmodule

/* tb/sv/positional_array_list_test.sv */
`timescale 1ns / 1ps

module positional_array_list_test;
    import pal_pkg::*;

    localparam int CAPACITY     = PAL_CAPACITY;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 470;
    localparam int CALM_ITEMS   = 60;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 160;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int WARMUP_ROWS  = 22;

    typedef struct {
        t_in_item  op;
        bit        fixed_answer;
        t_out_item answer;
    } t_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // shadow copy of the list, updated as each item is accepted
    logic signed [31:0] shadow_list [CAPACITY];
    int                 shadow_len = 0;
    t_out_item          list_answers [$];

    int cycle_count    = 0;
    int mismatches     = 0;
    int accepted_items = 0;
    bit calm_tail      = 1'b0;
    bit growing        = 1'b1;
    int dwell          = 0;

    int stall_left = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    t_row warmup [WARMUP_ROWS];

    positional_array_list #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic apply_list_op(input t_in_item it, input bit keep);
        t_status   st;
        t_out_item res;
        int        pos;
        int        k;
        pos = int'(it.position);
        st  = ST_OK;
        case (it.action)
            ACT_APPEND: begin
                if (shadow_len >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    shadow_list[shadow_len] = it.value;
                    shadow_len++;
                end
            end
            ACT_INSERT: begin
                if (shadow_len >= CAPACITY) begin
                    st = ST_FULL;
                end else if (pos < 1 || pos > shadow_len + 1) begin
                    st = ST_BADPOS;
                end else begin
                    for (k = shadow_len; k >= pos; k--)
                        shadow_list[k] = shadow_list[k - 1];
                    shadow_list[pos - 1] = it.value;
                    shadow_len++;
                end
            end
            ACT_DELETE: begin
                if (shadow_len == 0) begin
                    st = ST_EMPTY;
                end else if (pos < 1 || pos > shadow_len) begin
                    st = ST_BADPOS;
                end else begin
                    for (k = pos - 1; k + 1 < shadow_len; k++)
                        shadow_list[k] = shadow_list[k + 1];
                    shadow_len--;
                end
            end
            default: begin
                st = (shadow_len == 0) ? ST_EMPTY : ST_OK;
            end
        endcase
        if (keep) begin
            if (it.action == ACT_DUMP && shadow_len != 0) begin
                for (k = 0; k < shadow_len; k++) begin
                    res.status       = ST_OK;
                    res.element      = shadow_list[k];
                    res.length       = 6'(shadow_len);
                    res.final_result = (k == shadow_len - 1);
                    list_answers.push_back(res);
                end
            end else begin
                res.status       = st;
                res.element      = '0;
                res.length       = 6'(shadow_len);
                res.final_result = 1'b1;
                list_answers.push_back(res);
            end
        end
    endtask

    function automatic t_row step_row(t_action act, int pos, logic signed [31:0] val,
                                      bit fixed = 1'b0, t_status st = ST_OK, int len = 0);
        t_row r;
        r.op.action             = act;
        r.op.position           = 6'(pos);
        r.op.value              = val;
        r.fixed_answer          = fixed;
        r.answer.status         = st;
        r.answer.element        = '0;
        r.answer.length         = 6'(len);
        r.answer.final_result   = 1'b1;
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 32'sh8000_0000;
        else if (roll < 20)
            return 32'sh7fff_ffff;
        else if (roll < 30)
            return 32'($urandom_range(0, 15)) - 32'sd8;
        return $urandom;
    endfunction

    // growth phases lean on append/insert, shrink phases on delete
    function automatic t_in_item pick_list_op();
        t_in_item it;
        int       roll;
        roll = $urandom_range(0, 99);
        if (growing)
            it.action = (roll < 45) ? ACT_APPEND : (roll < 80) ? ACT_INSERT :
                        (roll < 90) ? ACT_DELETE : ACT_DUMP;
        else
            it.action = (roll < 15) ? ACT_APPEND : (roll < 25) ? ACT_INSERT :
                        (roll < 85) ? ACT_DELETE : ACT_DUMP;
        it.value    = pick_value();
        it.position = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 99) < 85) begin
            if (it.action == ACT_INSERT && shadow_len < CAPACITY)
                it.position = 6'($urandom_range(1, shadow_len + 1));
            else if (it.action == ACT_DELETE && shadow_len > 0)
                it.position = 6'($urandom_range(1, shadow_len));
        end
        return it;
    endfunction

    task automatic offer(input t_in_item it, input bit fixed, input t_out_item answer);
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        accepted_items++;
        apply_list_op(it, !fixed);
        if (fixed)
            list_answers.push_back(answer);
    endtask

    task automatic check_answer(input t_out_item got);
        t_out_item want;
        if (list_answers.size() == 0) begin
            report_mismatch($sformatf("unexpected item status %0d element %0d length %0d",
                                      got.status, got.element, got.length));
        end else begin
            want = list_answers.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.element !== want.element)
                report_mismatch($sformatf("element %0d, want %0d", got.element, want.element));
            if (got.length !== want.length)
                report_mismatch($sformatf("length %0d, want %0d", got.length, want.length));
            if (got.final_result !== want.final_result)
                report_mismatch($sformatf("final_result %0b, want %0b",
                                          got.final_result, want.final_result));
        end
    endtask

    // receiver: short random stalls, one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_answer(o_out_item);
        if (!hold_done && accepted_items >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        int n;
        warmup = '{
            step_row(ACT_DUMP,    0, 0,               1'b1, ST_EMPTY,  0),
            step_row(ACT_DELETE,  1, 0,               1'b1, ST_EMPTY,  0),
            step_row(ACT_DELETE,  0, 0,               1'b1, ST_EMPTY,  0),
            step_row(ACT_INSERT,  0, 5,               1'b1, ST_BADPOS, 0),
            step_row(ACT_INSERT,  2, 5,               1'b1, ST_BADPOS, 0),
            step_row(ACT_INSERT,  1, 32'sh8000_0000,  1'b1, ST_OK,     1),
            step_row(ACT_APPEND,  0, 32'sh7fff_ffff,  1'b1, ST_OK,     2),
            step_row(ACT_APPEND, 63, -1,              1'b1, ST_OK,     3),
            step_row(ACT_INSERT,  4, 0),
            step_row(ACT_INSERT,  2, 32'sh5555_5555),
            step_row(ACT_INSERT,  1, 32'shaaaa_aaaa),
            step_row(ACT_INSERT, 63, 7,               1'b1, ST_BADPOS, 6),
            step_row(ACT_INSERT,  8, 7,               1'b1, ST_BADPOS, 6),
            step_row(ACT_DELETE,  7, 0,               1'b1, ST_BADPOS, 6),
            step_row(ACT_DELETE,  0, 0,               1'b1, ST_BADPOS, 6),
            step_row(ACT_DUMP,    0, 0),
            step_row(ACT_DELETE,  1, 0),
            step_row(ACT_DELETE,  5, 0),
            step_row(ACT_DELETE,  2, 0),
            step_row(ACT_DUMP,   42, 32'sh1234_5678),
            step_row(ACT_APPEND, 21, 32'sh0f0f_0f0f),
            step_row(ACT_DUMP,   63, -1)
        };
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < WARMUP_ROWS; n++)
            offer(warmup[n].op, warmup[n].fixed_answer, warmup[n].answer);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm_tail = 1'b1;
            // linger a few items at full or empty, then turn around
            if (growing ? shadow_len == CAPACITY : shadow_len == 0) begin
                if (dwell == 0) begin
                    dwell = $urandom_range(3, 6);
                end else begin
                    dwell--;
                    if (dwell == 0)
                        growing = !growing;
                end
            end
            offer(pick_list_op(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (list_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
